[hw/rtl/tlfi_pkg.sv]
// shared types, constants and register map of the tvd limited face interpolator
`timescale 1ns / 1ps
package tlfi_pkg;

    localparam int WORD_W         = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int EPS_W          = 16;
    localparam int LIM_W          = 2;
    localparam int ADDR_W         = 3;
    localparam int REG_W          = 32;

    localparam logic [LIM_W-1:0] LIM_MINMOD   = 2'd0;
    localparam logic [LIM_W-1:0] LIM_VANLEER  = 2'd1;
    localparam logic [LIM_W-1:0] LIM_SUPERBEE = 2'd2;
    localparam logic [LIM_W-1:0] LIM_MC       = 2'd3;

    // register index, taken from paddr bit 2
    localparam logic REG_LIMITER = 1'b0;
    localparam logic REG_EPSILON = 1'b1;

    localparam logic [LIM_W-1:0] LIM_RESET = LIM_MINMOD;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    typedef struct packed {
        logic                     is_boundary;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
        logic signed [WORD_W-1:0] vel_z;
        logic signed [WORD_W-1:0] normal_x;
        logic signed [WORD_W-1:0] normal_y;
        logic signed [WORD_W-1:0] normal_z;
        logic signed [WORD_W-1:0] owner_value;
        logic signed [WORD_W-1:0] neighbor_value;
        logic signed [WORD_W-1:0] beyond_owner_value;
        logic signed [WORD_W-1:0] beyond_neighbor_value;
    } t_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] face_value;
        logic                     saturated;
    } t_out;

    typedef struct packed {
        logic [LIM_W-1:0] limiter_kind;
        logic [EPS_W-1:0] small_epsilon;
    } t_cfg;

    // per-face control carried alongside the ratio divider
    typedef struct packed {
        logic                     bnd;
        logic                     neg;
        logic                     zden;
        logic                     npos;
        logic                     nneg;
        logic                     big;
        logic signed [WORD_W-1:0] up;
        logic signed [WORD_W-1:0] dn;
    } t_side;

    // carried alongside the van leer divider
    typedef struct packed {
        t_side                    s;
        logic                     sat;
        logic signed [WORD_W-1:0] r;
    } t_side2;

    function automatic int den_mag_w(input int wb);
        return ((wb > EPS_W) ? wb : EPS_W) + 1;
    endfunction

endpackage

[hw/rtl/tlfi_cfg.sv]
// apb-style configuration registers: limiter kind and ratio epsilon
`timescale 1ns / 1ps
module tlfi_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlfi_pkg::ADDR_W-1:0] paddr,
    input  logic [tlfi_pkg::REG_W-1:0]  pwdata,
    output logic [tlfi_pkg::REG_W-1:0]  prdata,
    output logic                        pready,
    output tlfi_pkg::t_cfg              o_cfg
);
    import tlfi_pkg::*;

    t_cfg r_cfg;
    logic n_wr;

    assign pready = 1'b1;
    assign n_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limiter_kind  <= LIM_RESET;
            r_cfg.small_epsilon <= EPS_RESET;
        end else if (n_wr) begin
            case (paddr[2])
                REG_LIMITER: r_cfg.limiter_kind  <= pwdata[LIM_W-1:0];
                REG_EPSILON: r_cfg.small_epsilon <= pwdata[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LIMITER: prdata = {{(REG_W-LIM_W){1'b0}}, r_cfg.limiter_kind};
            REG_EPSILON: prdata = {{(REG_W-EPS_W){1'b0}}, r_cfg.small_epsilon};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/tlfi_div_pipe.sv]
// pipelined restoring divider, one quotient bit per stage, with sideband
`timescale 1ns / 1ps
module tlfi_div_pipe #(
    parameter int NQ = tlfi_pkg::FRAC_BITS_DEF + 1,
    parameter int NW = tlfi_pkg::DATA_WIDTH_DEF + tlfi_pkg::FRAC_BITS_DEF,
    parameter int DW = tlfi_pkg::DATA_WIDTH_DEF,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NQ-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    import tlfi_pkg::*;

    localparam int CW = NW + DW;

    logic          r_v   [0:NQ];
    logic [NW-1:0] r_rem [0:NQ];
    logic [DW-1:0] r_d   [0:NQ];
    logic [NQ-1:0] r_q   [0:NQ];
    logic [SW-1:0] r_s   [0:NQ];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_d[0]   <= i_den;
            r_q[0]   <= '0;
            r_s[0]   <= i_side;
        end
    end

    for (genvar k = 0; k < NQ; k++) begin : g_stage
        localparam int B = NQ - 1 - k;
        logic [CW-1:0] n_sh;
        logic [CW-1:0] n_diff;
        logic          n_ge;
        logic [NQ-1:0] n_q;

        assign n_sh   = {{NW{1'b0}}, r_d[k]} << B;
        assign n_ge   = {{DW{1'b0}}, r_rem[k]} >= n_sh;
        assign n_diff = {{DW{1'b0}}, r_rem[k]} - n_sh;

        always_comb begin
            n_q    = r_q[k];
            n_q[B] = n_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_ge ? n_diff[NW-1:0] : r_rem[k];
                r_d[k+1]   <= r_d[k];
                r_q[k+1]   <= n_q;
                r_s[k+1]   <= r_s[k];
            end
        end
    end

    assign o_valid = r_v[NQ];
    assign o_quo   = r_q[NQ];
    assign o_side  = r_s[NQ];

endmodule

[hw/rtl/tlfi_front.sv]
// front end: upwind sign from the dot product, cell selection, ratio operands
`timescale 1ns / 1ps
module tlfi_front #(
    parameter int WB = tlfi_pkg::DATA_WIDTH_DEF,
    parameter int FB = tlfi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  tlfi_pkg::t_in                 i_data,
    input  logic [tlfi_pkg::EPS_W-1:0]    i_eps,
    output logic                          o_valid,
    output logic [WB+FB-1:0]              o_num,
    output logic [tlfi_pkg::den_mag_w(WB)-1:0] o_den,
    output tlfi_pkg::t_side               o_side
);
    import tlfi_pkg::*;

    localparam int DMW = den_mag_w(WB);
    localparam int DNW = DMW + 1;
    localparam int PW  = 2 * WB;
    localparam int CW  = DMW + WB;

    // stage 1: input capture
    logic                 r1_v, r1_bnd;
    logic signed [WB-1:0] r1_vx, r1_vy, r1_vz, r1_nx, r1_ny, r1_nz;
    logic signed [WB-1:0] r1_own, r1_nb, r1_bo, r1_bn;
    // stage 2: products
    logic                 r2_v, r2_bnd;
    logic signed [PW-1:0] r2_p1, r2_p2, r2_p3;
    logic signed [WB-1:0] r2_own, r2_nb, r2_bo, r2_bn;
    // stage 3: upwind sign
    logic                 r3_v, r3_bnd, r3_nonneg;
    logic signed [WB-1:0] r3_own, r3_nb, r3_bo, r3_bn;
    // stage 4: numerator and denominator
    logic                  r4_v, r4_bnd;
    logic signed [WB-1:0]  r4_up, r4_dn;
    logic signed [WB:0]    r4_num;
    logic signed [DNW-1:0] r4_den;
    // stage 5: magnitudes
    logic                 r5_v;
    t_side                r5_s;
    logic [WB-1:0]        r5_na;
    logic [DMW-1:0]       r5_da;
    // stage 6: divider operands
    logic                 r6_v;
    t_side                r6_s;
    logic [WB+FB-1:0]     r6_num;
    logic [DMW-1:0]       r6_den;

    logic signed [PW+1:0]  n_sum;
    logic signed [WB-1:0]  n_up, n_dn, n_far;
    logic [WB:0]           n_na;
    logic [DNW-1:0]        n_da;
    logic [CW-1:0]         n_nsh, n_dsh;
    t_side                 n_s6;

    assign n_sum = (PW+2)'(r2_p1) + (PW+2)'(r2_p2) + (PW+2)'(r2_p3);

    always_comb begin
        n_up  = (r3_bnd || r3_nonneg) ? r3_own : r3_nb;
        n_dn  = r3_nonneg ? r3_nb : r3_own;
        n_far = r3_nonneg ? r3_bo : r3_bn;
    end

    assign n_na  = r4_num[WB] ? (WB+1)'(-r4_num) : r4_num;
    assign n_da  = r4_den[DNW-1] ? DNW'(-r4_den) : r4_den;
    assign n_nsh = CW'({r5_na, {FB{1'b0}}});
    assign n_dsh = {r5_da, {WB{1'b0}}};

    always_comb begin
        n_s6     = r5_s;
        n_s6.big = n_nsh >= n_dsh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_bnd <= i_data.is_boundary;
            r1_vx  <= i_data.vel_x[WB-1:0];
            r1_vy  <= i_data.vel_y[WB-1:0];
            r1_vz  <= i_data.vel_z[WB-1:0];
            r1_nx  <= i_data.normal_x[WB-1:0];
            r1_ny  <= i_data.normal_y[WB-1:0];
            r1_nz  <= i_data.normal_z[WB-1:0];
            r1_own <= i_data.owner_value[WB-1:0];
            r1_nb  <= i_data.neighbor_value[WB-1:0];
            r1_bo  <= i_data.beyond_owner_value[WB-1:0];
            r1_bn  <= i_data.beyond_neighbor_value[WB-1:0];

            r2_bnd <= r1_bnd;
            r2_p1  <= r1_vx * r1_nx;
            r2_p2  <= r1_vy * r1_ny;
            r2_p3  <= r1_vz * r1_nz;
            r2_own <= r1_own;
            r2_nb  <= r1_nb;
            r2_bo  <= r1_bo;
            r2_bn  <= r1_bn;

            r3_bnd    <= r2_bnd;
            r3_nonneg <= ~n_sum[PW+1];
            r3_own    <= r2_own;
            r3_nb     <= r2_nb;
            r3_bo     <= r2_bo;
            r3_bn     <= r2_bn;

            r4_bnd <= r3_bnd;
            r4_up  <= n_up;
            r4_dn  <= n_dn;
            r4_num <= (WB+1)'(n_up) - (WB+1)'(n_far);
            r4_den <= DNW'(n_dn) - DNW'(n_up) + DNW'({1'b0, i_eps});

            r5_s.bnd  <= r4_bnd;
            r5_s.neg  <= r4_num[WB] != r4_den[DNW-1];
            r5_s.zden <= r4_den == '0;
            r5_s.npos <= ~r4_num[WB] && (r4_num != '0);
            r5_s.nneg <= r4_num[WB];
            r5_s.big  <= 1'b0;
            r5_s.up   <= WORD_W'(r4_up);
            r5_s.dn   <= WORD_W'(r4_dn);
            r5_na     <= n_na[WB-1:0];
            r5_da     <= n_da[DMW-1:0];

            r6_s     <= n_s6;
            r6_num   <= {r5_na, {FB{1'b0}}};
            r6_den   <= (r5_da == '0) ? DMW'(1) : r5_da;
        end
    end

    assign o_valid = r6_v;
    assign o_num   = r6_num;
    assign o_den   = r6_den;
    assign o_side  = r6_s;

endmodule

[hw/rtl/tlfi_back.sv]
// back end: ratio saturation, limiter, face value sum and clip
`timescale 1ns / 1ps
module tlfi_back #(
    parameter int WB = tlfi_pkg::DATA_WIDTH_DEF,
    parameter int FB = tlfi_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [tlfi_pkg::LIM_W-1:0]   i_kind,
    input  logic                         i_valid,
    input  logic [WB-1:0]                i_quo,
    input  tlfi_pkg::t_side              i_side,
    output logic                         o_valid,
    output tlfi_pkg::t_out               o_data
);
    import tlfi_pkg::*;

    localparam int LW  = WB + 3;
    localparam int SW2 = $bits(t_side2);
    localparam logic [WB-1:0] LIM_P = {1'b0, {(WB-1){1'b1}}};
    localparam logic [WB-1:0] LIM_N = {1'b1, {(WB-1){1'b0}}};
    localparam logic [WB-1:0] ONE_W = WB'(1) << FB;
    localparam logic signed [LW-1:0] ONE_L = LW'(1) << FB;
    localparam logic signed [LW-1:0] TWO_L = LW'(2) << FB;

    function automatic logic signed [LW-1:0] smin(input logic signed [LW-1:0] a,
                                                   input logic signed [LW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [LW-1:0] smax(input logic signed [LW-1:0] a,
                                                   input logic signed [LW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // ratio finish
    logic                 r1_v, r1_sat;
    t_side                r1_s;
    logic signed [WB-1:0] r1_r;
    logic [WB-1:0]        n_lim, n_qm;
    logic                 n_satq;
    logic signed [WB-1:0] n_r;
    logic                 n_sat;

    always_comb begin
        n_lim  = i_side.neg ? LIM_N : LIM_P;
        n_satq = i_side.big || (i_quo > n_lim);
        n_qm   = n_satq ? n_lim : i_quo;
        n_r    = i_side.neg ? $signed(WB'(-n_qm)) : $signed(n_qm);
        n_sat  = n_satq;
        if (i_side.zden) begin
            n_sat = i_side.npos | i_side.nneg;
            if (i_side.npos) begin
                n_r = $signed(LIM_P);
            end else if (i_side.nneg) begin
                n_r = $signed(LIM_N);
            end else begin
                n_r = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s   <= i_side;
            r1_sat <= n_sat;
            r1_r   <= n_r;
        end
    end

    // van leer quotient 2r / (1 + r)
    logic             n_pos;
    logic [WB+FB-1:0] n_num2;
    logic [WB-1:0]    n_den2;
    t_side2           n_side2, d_side2;
    logic             d_v;
    logic [FB:0]      d_quo;

    always_comb begin
        n_pos   = ~r1_r[WB-1] && (r1_r != '0);
        n_num2  = n_pos ? {r1_r[WB-2:0], 1'b0, {FB{1'b0}}} : '0;
        n_den2  = n_pos ? ONE_W + r1_r : WB'(1);
        n_side2.s   = r1_s;
        n_side2.sat = r1_sat;
        n_side2.r   = WORD_W'(r1_r);
    end

    tlfi_div_pipe #(
        .NQ (FB + 1),
        .NW (WB + FB),
        .DW (WB),
        .SW (SW2)
    ) u_vl_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r1_v),
        .i_num   (n_num2),
        .i_den   (n_den2),
        .i_side  (n_side2),
        .o_valid (d_v),
        .o_quo   (d_quo),
        .o_side  (d_side2)
    );

    // limiter and difference
    logic signed [WB-1:0] n_rr, n_up, n_dn;
    logic signed [LW-1:0] n_re, n_2r, n_onep, n_half, n_psi;
    logic signed [WB:0]   n_diff;
    logic [WB:0]          n_absd;

    always_comb begin
        n_rr   = d_side2.r[WB-1:0];
        n_up   = d_side2.s.up[WB-1:0];
        n_dn   = d_side2.s.dn[WB-1:0];
        n_re   = LW'(n_rr);
        n_2r   = n_re <<< 1;
        n_onep = ONE_L + n_re;
        n_half = (n_onep + (n_onep[LW-1] ? LW'(1) : LW'(0))) >>> 1;
        case (i_kind)
            LIM_MINMOD:   n_psi = smax('0, smin(ONE_L, n_re));
            LIM_VANLEER:  n_psi = (n_re > 0) ? LW'(d_quo) : '0;
            LIM_SUPERBEE: n_psi = smax('0, smax(smin(n_2r, ONE_L), smin(n_re, TWO_L)));
            LIM_MC:       n_psi = smax('0, smin(smin(n_half, TWO_L), n_2r));
            default:      n_psi = '0;
        endcase
        n_diff = (WB+1)'(n_dn) - (WB+1)'(n_up);
        n_absd = n_diff[WB] ? (WB+1)'(-n_diff) : n_diff;
    end

    logic                 b1_v, b1_dneg, b1_sat, b1_bnd;
    logic [FB+1:0]        b1_psi;
    logic [WB-1:0]        b1_absd;
    logic signed [WB-1:0] b1_up;

    logic                 b2_v, b2_dneg, b2_sat, b2_bnd;
    logic [FB+WB+1:0]     b2_prod;
    logic signed [WB-1:0] b2_up;

    logic                 b3_v;
    t_out                 b3_out;

    logic [WB:0]          n_mag;
    logic signed [WB+1:0] n_upe, n_mage, n_res;
    logic                 n_ovh, n_ovl;
    logic signed [WB-1:0] n_clip;

    always_comb begin
        n_mag  = b2_prod[FB+WB+1:FB+1];
        n_upe  = (WB+2)'(b2_up);
        n_mage = $signed({1'b0, n_mag});
        n_res  = b2_dneg ? n_upe - n_mage : n_upe + n_mage;
        n_ovh  = ~n_res[WB+1] && (n_res[WB+1:WB-1] != 3'b000);
        n_ovl  = n_res[WB+1] && (n_res[WB+1:WB-1] != 3'b111);
        n_clip = n_ovh ? $signed(LIM_P) : (n_ovl ? $signed(LIM_N) : n_res[WB-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            b1_v <= 1'b0;
            b2_v <= 1'b0;
            b3_v <= 1'b0;
        end else if (i_en) begin
            b1_v <= d_v;
            b2_v <= b1_v;
            b3_v <= b2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            b1_psi  <= n_psi[FB+1:0];
            b1_absd <= n_absd[WB-1:0];
            b1_dneg <= n_diff[WB];
            b1_up   <= n_up;
            b1_sat  <= d_side2.sat;
            b1_bnd  <= d_side2.s.bnd;

            b2_prod <= b1_psi * b1_absd;
            b2_dneg <= b1_dneg;
            b2_up   <= b1_up;
            b2_sat  <= b1_sat;
            b2_bnd  <= b1_bnd;

            b3_out.face_value <= WORD_W'(b2_bnd ? b2_up : n_clip);
            b3_out.saturated  <= ~b2_bnd & (b2_sat | n_ovh | n_ovl);
        end
    end

    assign o_valid = b3_v;
    assign o_data  = b3_out;

endmodule

[hw/rtl/tvd_limited_face_interpolator.sv]
// top level of the tvd limited face interpolator
//
// Faces enter on the input channel (i_in_valid, o_in_stall, i_in_data) and
// face values leave on the output channel (o_out_valid, i_out_stall,
// o_out_data). A beat moves at a clock edge with valid high and stall low.
// One face can enter every cycle unless a result is stalled, so the sustained
// rate is one face per cycle. Internal widths are WB = min(DATA_WIDTH, 32)
// and FB = min(FRAC_BITS, WB - 2). Most of the pipeline is the ratio divider
// (one quotient bit per stage, WB stages) followed by the van leer divider
// (FB + 1 stages).
// When the receiver stalls a finished result, the whole pipeline holds and
// o_in_stall follows i_out_stall; nothing is lost or repeated.
// The apb port sets the limiter kind (address 0) and the ratio epsilon
// (address 4); write them only while no face is in flight.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets minmod with
// an epsilon of one raw unit.
`timescale 1ns / 1ps
module tvd_limited_face_interpolator #(
    parameter int DATA_WIDTH = tlfi_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = tlfi_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tlfi_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output tlfi_pkg::t_out              o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlfi_pkg::ADDR_W-1:0] paddr,
    input  logic [tlfi_pkg::REG_W-1:0]  pwdata,
    output logic [tlfi_pkg::REG_W-1:0]  prdata,
    output logic                        pready
);
    import tlfi_pkg::*;

    localparam int WB  = (DATA_WIDTH > WORD_W) ? WORD_W : DATA_WIDTH;
    localparam int FB  = (FRAC_BITS > WB - 2) ? WB - 2 : FRAC_BITS;
    localparam int DMW = den_mag_w(WB);
    localparam int SW  = $bits(t_side);

    t_cfg            cfg;
    logic            en;
    logic            f_v, d_v, b_v;
    logic [WB+FB-1:0] f_num;
    logic [DMW-1:0]  f_den;
    t_side           f_side, d_side;
    logic [WB-1:0]   d_quo;

    assign en         = ~(b_v & i_out_stall);
    assign o_in_stall = ~en;

    tlfi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tlfi_front #(
        .WB (WB),
        .FB (FB)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_eps   (cfg.small_epsilon),
        .o_valid (f_v),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_side  (f_side)
    );

    tlfi_div_pipe #(
        .NQ (WB),
        .NW (WB + FB),
        .DW (DMW),
        .SW (SW)
    ) u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_v),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (d_v),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    tlfi_back #(
        .WB (WB),
        .FB (FB)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_kind  (cfg.limiter_kind),
        .i_valid (d_v),
        .i_quo   (d_quo),
        .i_side  (d_side),
        .o_valid (b_v),
        .o_data  (o_out_data)
    );

    assign o_out_valid = b_v;

endmodule

[tb/sv/tb_tvd_limited_face_interpolator.sv]
// self-checking testbench for the tvd limited face interpolator
`timescale 1ns / 1ps
module tb_tvd_limited_face_interpolator;
    import tlfi_pkg::*;

    localparam int ONE_Q    = 1 << 16;
    localparam int LATENCY  = 61;
    localparam int WD_LIMIT = 4000;

    class face_scoreboard;
        logic [LIM_W-1:0] kind;
        logic [EPS_W-1:0] eps;
        t_out             face_q[$];
        int               mismatches;
        int               checked;
        int               sat_seen;
        int               bnd_seen;

        function new();
            kind = LIM_RESET;
            eps  = EPS_RESET;
        endfunction

        function automatic longint unsigned frac_div(longint unsigned n, longint unsigned d,
                                                     longint unsigned lim, inout bit sat);
            longint unsigned q;
            longint unsigned rem;
            q   = n / d;
            rem = n % d;
            if (q > (lim >> 16)) begin
                sat = 1;
                return lim;
            end
            for (int i = 0; i < 16; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    q   = q | 1;
                end
            end
            if (q > lim) begin
                sat = 1;
                return lim;
            end
            return q;
        endfunction

        function automatic longint limit_psi(longint r);
            bit     unused;
            longint t;
            unused = 0;
            case (kind)
                LIM_MINMOD: begin
                    t = (r < ONE_Q) ? r : ONE_Q;
                    return (t > 0) ? t : 0;
                end
                LIM_VANLEER: begin
                    if (r <= 0) return 0;
                    return longint'(frac_div(2 * r, ONE_Q + r, 2 * ONE_Q, unused));
                end
                LIM_SUPERBEE: begin
                    t = ((2 * r) < ONE_Q) ? 2 * r : ONE_Q;
                    if (((r < 2 * ONE_Q) ? r : 2 * ONE_Q) > t) t = (r < 2 * ONE_Q) ? r : 2 * ONE_Q;
                    return (t > 0) ? t : 0;
                end
                default: begin
                    t = (ONE_Q + r) / 2;
                    if (t > 2 * ONE_Q) t = 2 * ONE_Q;
                    if (t > 2 * r) t = 2 * r;
                    return (t > 0) ? t : 0;
                end
            endcase
        endfunction

        function automatic t_out face_value_of(t_in f);
            t_out                  o;
            logic signed [66:0]    dot;
            longint                up, dn, far, num, den, r, psi, diff, res, mag;
            longint unsigned       q, lim;
            bit                    sat, neg;
            sat = 0;
            if (f.is_boundary) begin
                o.face_value = f.owner_value;
                o.saturated  = 1'b0;
                return o;
            end
            dot = longint'(f.vel_x) * longint'(f.normal_x);
            dot = dot + longint'(f.vel_y) * longint'(f.normal_y);
            dot = dot + longint'(f.vel_z) * longint'(f.normal_z);
            if (dot >= 0) begin
                up  = longint'(f.owner_value);
                dn  = longint'(f.neighbor_value);
                far = longint'(f.beyond_owner_value);
            end else begin
                up  = longint'(f.neighbor_value);
                dn  = longint'(f.owner_value);
                far = longint'(f.beyond_neighbor_value);
            end
            num = up - far;
            den = dn - up + longint'(eps);
            if (den == 0) begin
                if (num > 0) begin
                    r = 64'sd2147483647;
                    sat = 1;
                end else if (num < 0) begin
                    r = -64'sd2147483648;
                    sat = 1;
                end else begin
                    r = 0;
                end
            end else begin
                neg = (num < 0) != (den < 0);
                lim = neg ? 64'd2147483648 : 64'd2147483647;
                q   = frac_div((num < 0) ? -num : num, (den < 0) ? -den : den, lim, sat);
                r   = neg ? -longint'(q) : longint'(q);
            end
            psi  = limit_psi(r);
            diff = dn - up;
            mag  = (psi * ((diff < 0) ? -diff : diff)) >>> 17;
            res  = (diff < 0) ? up - mag : up + mag;
            if (res > 64'sd2147483647) begin
                res = 64'sd2147483647;
                sat = 1;
            end else if (res < -64'sd2147483648) begin
                res = -64'sd2147483648;
                sat = 1;
            end
            o.face_value = res[31:0];
            o.saturated  = sat;
            return o;
        endfunction

        function void note_face(t_in f);
            face_q.insert(face_q.size(), face_value_of(f));
            if (f.is_boundary) bnd_seen++;
        endfunction

        function void check_face(t_out got);
            t_out want;
            checked++;
            if (got.saturated) sat_seen++;
            if (face_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: face_value=%h saturated=%b",
                             got.face_value, got.saturated);
                return;
            end
            want = face_q.pop_front();
            if (got.face_value !== want.face_value || got.saturated !== want.saturated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: face_value exp %h got %h, saturated exp %b got %b",
                             want.face_value, got.face_value, want.saturated, got.saturated);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in               i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out              o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [REG_W-1:0]  pwdata;
    logic [REG_W-1:0]  prdata;
    logic              pready;

    face_scoreboard sb;
    bit             idle_on;
    int             hold_req;
    int             hold_left;
    int             burst_left;
    int             quiet_cycles;

    tvd_limited_face_interpolator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // result side: check accepted beats and watch for a stuck pipeline; the stall value is picked at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_face(o_out_data);
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("tb_tvd_limited_face_interpolator: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_out_stall = 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst_left  = $urandom_range(0, 3);
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    task automatic apb_write(logic idx, logic [REG_W-1:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_LIMITER) sb.kind = val[LIM_W-1:0];
        else sb.eps = val[EPS_W-1:0];
    endtask

    task automatic send_face(t_in f);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = f;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_face(f);
    endtask

    task automatic finish_phase();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.face_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_word(int spread);
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($urandom_range(0, 2) - 1);
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 2 * spread)) - spread);
        endcase
    endfunction

    function automatic t_in random_face();
        t_in f;
        int  spread;
        spread                  = ($urandom_range(0, 3) == 0) ? 32'h00ff_ffff : 4 * ONE_Q;
        f.is_boundary           = ($urandom_range(0, 9) == 0);
        f.vel_x                 = pick_word(spread);
        f.vel_y                 = pick_word(spread);
        f.vel_z                 = pick_word(spread);
        f.normal_x              = pick_word(ONE_Q);
        f.normal_y              = pick_word(ONE_Q);
        f.normal_z              = pick_word(ONE_Q);
        f.owner_value           = pick_word(spread);
        f.neighbor_value        = ($urandom_range(0, 7) == 0) ? f.owner_value : pick_word(spread);
        f.beyond_owner_value    = pick_word(spread);
        f.beyond_neighbor_value = pick_word(spread);
        return f;
    endfunction

    function automatic t_in make_face(logic bnd, logic [31:0] vx, logic [31:0] nx,
                                      logic [31:0] own, logic [31:0] nb,
                                      logic [31:0] bo, logic [31:0] bn);
        t_in f;
        f = '0;
        f.is_boundary           = bnd;
        f.vel_x                 = vx;
        f.vel_y                 = vx;
        f.vel_z                 = vx;
        f.normal_x              = nx;
        f.normal_y              = nx;
        f.normal_z              = nx;
        f.owner_value           = own;
        f.neighbor_value        = nb;
        f.beyond_owner_value    = bo;
        f.beyond_neighbor_value = bn;
        return f;
    endfunction

    task automatic directed_faces();
        send_face(make_face(1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0));
        send_face(make_face(1, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1, 2));
        send_face(make_face(0, ONE_Q, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, ONE_Q, 5 * ONE_Q));
        send_face(make_face(0, -ONE_Q, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, ONE_Q, 5 * ONE_Q));
        send_face(make_face(0, 0, 0, ONE_Q, 4 * ONE_Q, 0, 7 * ONE_Q));
        send_face(make_face(0, ONE_Q, ONE_Q, 5 * ONE_Q, 5 * ONE_Q, 0, 0));
        send_face(make_face(0, 32'h8000_0000, 32'h8000_0000, 0, ONE_Q, ONE_Q, 0));
        send_face(make_face(0, 32'h8000_0000, 32'h7fff_ffff, 0, ONE_Q, 0, ONE_Q));
        send_face(make_face(0, ONE_Q, ONE_Q, 32'h7fff_ffff, 32'h7fff_fffe,
                            32'h8000_0000, 0));
        send_face(make_face(0, ONE_Q, ONE_Q, 32'h8000_0000, 32'h7fff_ffff,
                            32'h7fff_ffff, 0));
        send_face(make_face(0, ONE_Q, ONE_Q, ONE_Q, 32'h7fff_ffff, 0, 0));
        send_face(make_face(0, ONE_Q, ONE_Q, 3 * ONE_Q, ONE_Q, 2 * ONE_Q, 0));
        send_face(make_face(0, -1, 1, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000));
    endtask

    initial begin
        logic [LIM_W-1:0] kinds [6];
        logic [EPS_W-1:0] epss  [6];
        sb           = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_stall  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        idle_on      = 1'b1;
        hold_req     = 0;
        hold_left    = 0;
        burst_left   = 0;
        quiet_cycles = 0;
        kinds = '{LIM_MINMOD, LIM_VANLEER, LIM_SUPERBEE, LIM_MC, LIM_VANLEER, LIM_MINMOD};
        epss  = '{16'd1, 16'hffff, 16'd0, 16'd1, 16'($urandom_range(1, 65535)), 16'd0};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        directed_faces();
        finish_phase();
        for (int p = 0; p < 6; p++) begin
            apb_write(REG_LIMITER, REG_W'(kinds[p]));
            apb_write(REG_EPSILON, REG_W'(epss[p]));
            if (p == 5) idle_on = 1'b0;
            for (int n = 0; n < 173; n++) begin
                if (p == 2 && n == 20) hold_req = 300;
                send_face(random_face());
            end
            if (p == 1) directed_faces();
            finish_phase();
        end
        $display("checked %0d face values (%0d boundary, %0d saturated) over six settings",
                 sb.checked, sb.bnd_seen, sb.sat_seen);
        $display("all four limiters, epsilon 0 / 1 / 65535, random stalls and a long hold");
        if (sb.mismatches == 0 && sb.face_q.size() == 0) begin
            $display("tb_tvd_limited_face_interpolator: PASS");
        end else begin
            $display("tb_tvd_limited_face_interpolator: FAIL");
        end
        $finish;
    end

endmodule
